// ----- rtl/urpn_pkg.sv -----
// ----------------------------------------------------------------------------
// urpn_pkg
// shared types and constants of the rgb packet node with pwm led drive
// ----------------------------------------------------------------------------
package urpn_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] PWM_WRAP     = 8'd255;
    localparam logic [BYTE_W-1:0] HEADER_BYTES = 8'd4;

    // parser positions
    localparam logic [BYTE_W-1:0] POS_IDLE  = 8'd0;
    localparam logic [BYTE_W-1:0] POS_RED   = 8'd1;
    localparam logic [BYTE_W-1:0] POS_GREEN = 8'd2;
    localparam logic [BYTE_W-1:0] POS_BLUE  = 8'd3;

    localparam logic [BYTE_W-1:0] DUTY_RESET = 8'd1;

    // item kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } t_duty;

    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              red_on;
        logic              green_on;
        logic              blue_on;
        logic              packet_active;
    } t_result;

endpackage

// ----- rtl/urpn_parser.sv -----
// ----------------------------------------------------------------------------
// urpn_parser
// packet parser: length byte, three duty bytes, then forwarded bytes
// ----------------------------------------------------------------------------
module urpn_parser
    import urpn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_tx_valid,
    output logic [BYTE_W-1:0] o_tx_byte,
    output logic              o_active,
    output t_duty             o_duty
);

    logic [BYTE_W-1:0] r_pos,  n_pos;
    logic [BYTE_W-1:0] r_len,  n_len;
    t_duty             r_duty, n_duty;
    logic [BYTE_W-1:0] w_inc;

    assign w_inc = r_pos + 8'd1;

    always_comb begin
        n_pos      = r_pos;
        n_len      = r_len;
        n_duty     = r_duty;
        o_tx_valid = 1'b0;
        o_tx_byte  = '0;
        if (i_en) begin
            if (r_pos == POS_IDLE) begin
                n_len = i_byte;
                n_pos = POS_RED;
            end else begin
                unique case (r_pos)
                    POS_RED:   n_duty.red   = i_byte;
                    POS_GREEN: n_duty.green = i_byte;
                    POS_BLUE:  n_duty.blue  = i_byte;
                    default: begin
                        o_tx_valid = 1'b1;
                        o_tx_byte  = i_byte;
                    end
                endcase
                // packet end
                if (w_inc >= HEADER_BYTES && w_inc >= r_len) begin
                    n_pos = POS_IDLE;
                end else begin
                    n_pos = w_inc;
                end
            end
        end
    end

    assign o_active = (n_pos != POS_IDLE);
    assign o_duty   = r_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= POS_IDLE;
            r_len        <= '0;
            r_duty.red   <= DUTY_RESET;
            r_duty.green <= DUTY_RESET;
            r_duty.blue  <= DUTY_RESET;
        end else begin
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_duty <= n_duty;
        end
    end

endmodule

// ----- rtl/urpn_pwm.sv -----
// ----------------------------------------------------------------------------
// urpn_pwm
// pwm counter with a period of 255 ticks and three led levels
// ----------------------------------------------------------------------------
module urpn_pwm
    import urpn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tick,
    input  t_duty      i_duty,
    output logic [2:0] o_levels
);

    logic [BYTE_W-1:0] r_cnt, n_cnt;
    logic [2:0]        r_lvl, n_lvl;
    logic [BYTE_W-1:0] w_cnt;
    logic [2:0]        w_lvl;

    always_comb begin
        w_cnt = r_cnt;
        w_lvl = r_lvl;
        if (r_cnt == PWM_WRAP) begin
            w_cnt = '0;
            w_lvl = 3'b111;
        end
        n_cnt = r_cnt;
        n_lvl = r_lvl;
        if (i_tick) begin
            n_lvl[0] = w_lvl[0] & (w_cnt != i_duty.red);
            n_lvl[1] = w_lvl[1] & (w_cnt != i_duty.green);
            n_lvl[2] = w_lvl[2] & (w_cnt != i_duty.blue);
            n_cnt    = w_cnt + 8'd1;
        end
    end

    assign o_levels = n_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_lvl <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_lvl <= n_lvl;
        end
    end

endmodule

// ----- rtl/uart_rgb_packet_node_pwm.sv -----
// ----------------------------------------------------------------------------
// uart_rgb_packet_node_pwm
// rgb led node: parses byte packets into duty values, forwards the payload
// and drives three pwm led levels from timer ticks
// the result beat is registered, shown in the cycle after its input beat is accepted
// throughput: one beat per cycle while results are taken, the result register set by the accepted beat
// the input side stalls only while a held result is not taken
// reset: synchronous active low, duties to 1, counter, levels and parser idle
// ----------------------------------------------------------------------------
module uart_rgb_packet_node_pwm
    import urpn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_tx_valid,
    output logic [BYTE_W-1:0] o_tx_byte,
    output logic              o_red_on,
    output logic              o_green_on,
    output logic              o_blue_on,
    output logic              o_packet_active
);

    logic              w_accept;
    logic              w_tx_valid;
    logic [BYTE_W-1:0] w_tx_byte;
    logic              w_active;
    logic [2:0]        w_levels;
    t_duty             w_duty;
    t_result           n_res;
    t_result           r_res;
    logic              r_out_valid;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    urpn_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_accept && (i_op == OP_BYTE)),
        .i_byte     (i_rx_byte),
        .o_tx_valid (w_tx_valid),
        .o_tx_byte  (w_tx_byte),
        .o_active   (w_active),
        .o_duty     (w_duty)
    );

    urpn_pwm u_pwm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (w_accept && (i_op == OP_TICK)),
        .i_duty   (w_duty),
        .o_levels (w_levels)
    );

    always_comb begin
        n_res.tx_valid      = w_tx_valid;
        n_res.tx_byte       = w_tx_byte;
        n_res.red_on        = w_levels[0];
        n_res.green_on      = w_levels[1];
        n_res.blue_on       = w_levels[2];
        n_res.packet_active = w_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_tx_valid      = r_res.tx_valid;
    assign o_tx_byte       = r_res.tx_byte;
    assign o_red_on        = r_res.red_on;
    assign o_green_on      = r_res.green_on;
    assign o_blue_on       = r_res.blue_on;
    assign o_packet_active = r_res.packet_active;

endmodule

// ----- sim/uart_rgb_packet_node_pwm_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rgb_packet_node_pwm_tb
// drives packets of bytes and timer ticks into the rgb packet node, predicts
// duty updates, forwarded bytes, packet light and pwm led levels per beat and
// checks every result beat in order, with random idling on both sides
// ----------------------------------------------------------------------------
module uart_rgb_packet_node_pwm_tb;
    import urpn_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 1200;
    localparam int CALM_TAIL    = 150;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 150;

    typedef struct {
        logic              op;
        logic [BYTE_W-1:0] rx_byte;
    } t_node_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_op = OP_TICK;
    logic [BYTE_W-1:0] i_rx_byte = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_tx_valid;
    logic [BYTE_W-1:0] o_tx_byte;
    logic              o_red_on;
    logic              o_green_on;
    logic              o_blue_on;
    logic              o_packet_active;

    t_node_beat pending_beats[$];
    t_result    expected_results[$];
    t_node_beat next_beat;
    t_result    want;

    // predictor state
    logic [BYTE_W-1:0] parse_pos = POS_IDLE;
    logic [BYTE_W-1:0] pkt_len = '0;
    t_duty             duty = {DUTY_RESET, DUTY_RESET, DUTY_RESET};
    logic [BYTE_W-1:0] pwm_count = '0;
    logic [2:0]        leds = 3'b000;
    logic              busy = 1'b0;

    int total_beats = 0;
    int beats_taken = 0;
    int results_seen = 0;
    int errors = 0;
    int wraps = 0;
    int bytes_forwarded = 0;
    int packets_closed = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit held_once = 1'b0;
    bit calm = 1'b0;

    uart_rgb_packet_node_pwm DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_tx_valid      (o_tx_valid),
        .o_tx_byte       (o_tx_byte),
        .o_red_on        (o_red_on),
        .o_green_on      (o_green_on),
        .o_blue_on       (o_blue_on),
        .o_packet_active (o_packet_active)
    );

    function automatic t_result node_step(logic op, logic [BYTE_W-1:0] b);
        t_result r;
        r = '0;
        if (op == OP_BYTE) begin
            if (parse_pos == POS_IDLE) begin
                pkt_len   = b;
                parse_pos = POS_RED;
                busy      = 1'b1;
            end else begin
                case (parse_pos)
                    POS_RED:   duty.red = b;
                    POS_GREEN: duty.green = b;
                    POS_BLUE:  duty.blue = b;
                    default: begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = b;
                        bytes_forwarded++;
                    end
                endcase
                parse_pos = parse_pos + 1'b1;
                if (parse_pos >= HEADER_BYTES && parse_pos >= pkt_len) begin
                    parse_pos = POS_IDLE;
                    busy      = 1'b0;
                    packets_closed++;
                end
            end
        end else begin
            if (pwm_count == PWM_WRAP) begin
                leds      = 3'b111;
                pwm_count = '0;
                wraps++;
            end
            if (pwm_count == duty.red) leds[0] = 1'b0;
            if (pwm_count == duty.green) leds[1] = 1'b0;
            if (pwm_count == duty.blue) leds[2] = 1'b0;
            pwm_count = pwm_count + 1'b1;
        end
        r.red_on        = leds[0];
        r.green_on      = leds[1];
        r.blue_on       = leds[2];
        r.packet_active = busy;
        return r;
    endfunction

    task automatic push_byte(logic [BYTE_W-1:0] b);
        pending_beats.push_back('{op: OP_BYTE, rx_byte: b});
    endtask

    task automatic push_ticks(int n);
        for (int k = 0; k < n; k++) begin
            pending_beats.push_back('{op: OP_TICK, rx_byte: BYTE_W'($urandom)});
        end
    endtask

    // header, three duties, then payload up to the length; ticks may interleave
    task automatic push_packet(logic [BYTE_W-1:0] len);
        int body;
        body = (len < HEADER_BYTES) ? 3 : int'(len) - 1;
        push_byte(len);
        for (int k = 0; k < body; k++) begin
            if ($urandom_range(0, 3) == 0) push_ticks($urandom_range(1, 3));
            push_byte(BYTE_W'($urandom));
        end
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            calm <= (pending_beats.size() < CALM_TAIL);
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    next_beat = pending_beats.pop_front();
                    i_valid   <= 1'b1;
                    i_op      <= next_beat.op;
                    i_rx_byte <= next_beat.rx_byte;
                    if (!calm && $urandom_range(0, 7) == 0) begin
                        send_gap <= $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off to back up the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (!held_once && results_seen >= HOLD_AFTER) begin
            held_once <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            i_ready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // monitor: check result beats, then predict for accepted input beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_tx_valid !== want.tx_valid) begin
                        $error("tx_valid expected %0d got %0d", want.tx_valid, o_tx_valid);
                        errors++;
                    end
                    if (o_tx_byte !== want.tx_byte) begin
                        $error("tx_byte expected %0d got %0d", want.tx_byte, o_tx_byte);
                        errors++;
                    end
                    if (o_red_on !== want.red_on) begin
                        $error("red_on expected %0d got %0d", want.red_on, o_red_on);
                        errors++;
                    end
                    if (o_green_on !== want.green_on) begin
                        $error("green_on expected %0d got %0d", want.green_on, o_green_on);
                        errors++;
                    end
                    if (o_blue_on !== want.blue_on) begin
                        $error("blue_on expected %0d got %0d", want.blue_on, o_blue_on);
                        errors++;
                    end
                    if (o_packet_active !== want.packet_active) begin
                        $error("packet_active expected %0d got %0d",
                               want.packet_active, o_packet_active);
                        errors++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                expected_results.push_back(node_step(i_op, i_rx_byte));
                beats_taken <= beats_taken + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int base;
        bit long_done;
        long_done = 1'b0;

        // ticks with the byte lane at its extremes, then short and exact lengths
        pending_beats.push_back('{op: OP_TICK, rx_byte: 8'hFF});
        pending_beats.push_back('{op: OP_TICK, rx_byte: 8'h00});
        push_byte(8'd0);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h80);
        push_byte(8'd3);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'd4);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'd6);
        push_byte(8'd1);
        push_byte(8'd2);
        push_byte(8'd3);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_ticks(1);
        base = pending_beats.size();

        while (pending_beats.size() < base + RANDOM_BEATS) begin
            push_ticks($urandom_range(0, 30));
            if ($urandom_range(0, 9) == 0) begin
                // stray bytes that open packets out of step
                for (int k = $urandom_range(1, 3); k > 0; k--) push_byte(BYTE_W'($urandom));
            end else if (!long_done && pending_beats.size() > base + RANDOM_BEATS / 2) begin
                long_done = 1'b1;
                push_packet(8'd255);
            end else if ($urandom_range(0, 7) == 0) begin
                push_packet(BYTE_W'($urandom_range(13, 40)));
            end else begin
                push_packet(BYTE_W'($urandom_range(0, 12)));
            end
        end
        total_beats = pending_beats.size();

        while (beats_taken < total_beats || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end

        $display("%0d beats in, %0d results checked, %0d packets closed, %0d bytes forwarded",
                 beats_taken, results_seen, packets_closed, bytes_forwarded);
        $display("%0d pwm wraps seen, long receiver hold-off done: %0d", wraps, held_once);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/urpn_pkg.sv
rtl/urpn_parser.sv
rtl/urpn_pwm.sv
rtl/uart_rgb_packet_node_pwm.sv
sim/uart_rgb_packet_node_pwm_tb.sv
